@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the string hash unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define CFTHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define CFTHS_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ hdl/cfths_pkg.sv @@
// ----------------------------------------------------------------------------
// cfths_pkg
// Constants, types and helper functions of the case-folded string hash unit.
// ----------------------------------------------------------------------------
package cfths_pkg;

   // Table geometry.
   localparam int NUM_TYPES   = 5;
   localparam int GROUP_WORDS = 256;
   localparam int TABLE_WORDS = NUM_TYPES * GROUP_WORDS;
   localparam int ADDR_W      = $clog2(TABLE_WORDS);
   localparam int GROUP_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int CHAR_W      = 8;
   localparam int HTYPE_W     = 3;
   localparam int WORD_W      = 32;

   // Hash seeds.
   localparam logic [WORD_W-1:0] MIX_A_INIT = 32'h7FED_7FED;
   localparam logic [WORD_W-1:0] MIX_B_INIT = 32'hEEEE_EEEE;
   localparam logic [WORD_W-1:0] MIX_B_ADD  = 32'd3;

   // Table generator: seed' = (seed * 125 + 3) mod 0x2AAAAB.
   localparam int SEED_W      = 22;
   localparam int GEN_MOD_INT = 32'h002A_AAAB;
   localparam int GEN_MUL_INT = 125;
   localparam int GEN_ADD_INT = 3;
   localparam logic [SEED_W-1:0] SEED_INIT = 22'h10_0001;
   localparam logic [SEED_W-1:0] GEN_MOD   = SEED_W'(GEN_MOD_INT);
   // Width of seed * 125 + 3, and the reciprocal used for the reduction.
   localparam int X_W      = $clog2(GEN_MOD_INT * GEN_MUL_INT + GEN_ADD_INT + 1);
   localparam int RECIP    = (1 << X_W) / GEN_MOD_INT;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int REM_W    = SEED_W + 1;
   localparam int HALF_W   = 16;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   // Queue depths.
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // One classified byte, as passed from the front end to the back end.
   typedef struct packed {
      logic              last;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] chr;
   } cmd_type;

   // Table write from the generator.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } tbl_wr_type;

   function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   // Word (group g, byte c) sits at g * 256 + c.
   function automatic logic [ADDR_W-1:0] make_addr(input logic [GROUP_W-1:0] g,
                                                   input logic [CHAR_W-1:0]  c);
      return ADDR_W'({g, c});
   endfunction

endpackage

@@ hdl/cfths_gen.sv @@
// ----------------------------------------------------------------------------
// cfths_gen
// Crypt table generator: fills the table from the modular LCG after reset.
// ----------------------------------------------------------------------------
module cfths_gen (
   input  logic                 clock,
   input  logic                 reset,
   output cfths_pkg::tbl_wr_type tbl_wr,
   output logic                 fill_done
);

   localparam logic [1:0] ST_MUL = 2'd0;
   localparam logic [1:0] ST_EST = 2'd1;
   localparam logic [1:0] ST_SUB = 2'd2;
   localparam logic [1:0] ST_FIX = 2'd3;

   localparam int PROD_W = cfths_pkg::X_W + cfths_pkg::RECIP_W;
   localparam logic [cfths_pkg::GROUP_W-1:0] LAST_GROUP =
      cfths_pkg::GROUP_W'(cfths_pkg::NUM_TYPES - 1);

   logic [1:0]                          state_ff, state_in;
   logic                                done_ff, done_in;
   logic                                half_ff, half_in;
   logic [cfths_pkg::SEED_W-1:0]        seed_ff, seed_in;
   logic [cfths_pkg::X_W-1:0]           x_ff, x_in;
   logic [cfths_pkg::RECIP_W-1:0]       q_ff, q_in;
   logic [cfths_pkg::REM_W-1:0]         r_ff, r_in;
   logic [cfths_pkg::HALF_W-1:0]        hi_ff, hi_in;
   logic [cfths_pkg::CHAR_W-1:0]        c_ff, c_in;
   logic [cfths_pkg::GROUP_W-1:0]       g_ff, g_in;
   logic [PROD_W-1:0]                   prod;
   logic [cfths_pkg::X_W-1:0]           qm;
   logic [cfths_pkg::SEED_W-1:0]        draw;
   logic                                word_end;
   logic                                last_word;

   // Reduction: the reciprocal estimate is the quotient or one below it,
   // so one conditional subtract after the remainder finishes the job.
   assign prod = PROD_W'(x_ff) * PROD_W'(cfths_pkg::RECIP);
   assign qm   = cfths_pkg::X_W'(q_ff) * cfths_pkg::X_W'(cfths_pkg::GEN_MOD);
   assign draw = (r_ff >= cfths_pkg::REM_W'(cfths_pkg::GEN_MOD)) ?
                 cfths_pkg::SEED_W'(r_ff - cfths_pkg::REM_W'(cfths_pkg::GEN_MOD)) :
                 cfths_pkg::SEED_W'(r_ff);

   assign word_end  = !done_ff && (state_ff == ST_FIX) && half_ff;
   assign last_word = (c_ff == {cfths_pkg::CHAR_W{1'b1}}) && (g_ff == LAST_GROUP);

   assign tbl_wr.en   = word_end;
   assign tbl_wr.addr = cfths_pkg::make_addr(g_ff, c_ff);
   assign tbl_wr.data = {hi_ff, draw[cfths_pkg::HALF_W-1:0]};
   assign fill_done   = done_ff;

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      half_in  = half_ff;
      seed_in  = seed_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      hi_in    = hi_ff;
      c_in     = c_ff;
      g_in     = g_ff;
      if (!done_ff) begin
         case (state_ff)
            ST_MUL: begin
               x_in = cfths_pkg::X_W'(seed_ff) * cfths_pkg::X_W'(cfths_pkg::GEN_MUL_INT)
                      + cfths_pkg::X_W'(cfths_pkg::GEN_ADD_INT);
               state_in = ST_EST;
            end
            ST_EST: begin
               q_in     = prod[PROD_W-1:cfths_pkg::X_W];
               state_in = ST_SUB;
            end
            ST_SUB: begin
               r_in     = cfths_pkg::REM_W'(x_ff - qm);
               state_in = ST_FIX;
            end
            ST_FIX: begin
               seed_in  = draw;
               state_in = ST_MUL;
               if (!half_ff) begin
                  hi_in   = draw[cfths_pkg::HALF_W-1:0];
                  half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  if (last_word) begin
                     done_in = 1'b1;
                  end else if (g_ff == LAST_GROUP) begin
                     g_in = '0;
                     c_in = c_ff + 1'b1;
                  end else begin
                     g_in = g_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_in = ST_MUL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MUL;
         done_ff  <= 1'b0;
         half_ff  <= 1'b0;
         seed_ff  <= cfths_pkg::SEED_INIT;
         c_ff     <= '0;
         g_ff     <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         half_ff  <= half_in;
         seed_ff  <= seed_in;
         c_ff     <= c_in;
         g_ff     <= g_in;
      end
      x_ff  <= x_in;
      q_ff  <= q_in;
      r_ff  <= r_in;
      hi_ff <= hi_in;
   end

endmodule

@@ hdl/cfths_front.sv @@
// ----------------------------------------------------------------------------
// cfths_front
// Accepts string bytes, folds case, picks the table word and queues the beat.
// ----------------------------------------------------------------------------
module cfths_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fill_done,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [cfths_pkg::CHAR_W-1:0]       req_char_in,
   input  logic [cfths_pkg::HTYPE_W-1:0]      req_hash_type,
   output cfths_pkg::cmd_type                 cmd,
   output logic                               cmd_valid,
   input  logic                               cmd_pop
);

   localparam logic [cfths_pkg::HTYPE_W-1:0] TYPE_LIMIT =
      cfths_pkg::HTYPE_W'(cfths_pkg::NUM_TYPES);
   localparam logic [cfths_pkg::HTYPE_W-1:0] TYPE_LAST =
      cfths_pkg::HTYPE_W'(cfths_pkg::NUM_TYPES - 1);

   cfths_pkg::cmd_type                   entries_ff [cfths_pkg::CMDQ_DEPTH];
   cfths_pkg::cmd_type                   entry_in;
   logic [cfths_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cfths_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cfths_pkg::CMDQ_CNT_W-1:0]     count_ff, count_in;
   logic [cfths_pkg::HTYPE_W-1:0]        type_clamped;
   logic [cfths_pkg::CHAR_W-1:0]         folded;
   logic                                 push;
   logic                                 pop;

   // A group number past the last one uses the last group.
   assign type_clamped = (req_hash_type >= TYPE_LIMIT) ? TYPE_LAST : req_hash_type;
   assign folded       = cfths_pkg::fold_lower(req_char_in);

   always_comb begin
      entry_in.last = (req_char_in == cfths_pkg::CHAR_NUL);
      entry_in.chr  = folded;
      entry_in.addr = cfths_pkg::make_addr(cfths_pkg::GROUP_W'(type_clamped), folded);
   end

   assign req_full  = !fill_done ||
                      (count_ff == cfths_pkg::CMDQ_CNT_W'(cfths_pkg::CMDQ_DEPTH));
   assign push      = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ hdl/cfths_back.sv @@
// ----------------------------------------------------------------------------
// cfths_back
// Holds the crypt table, mixes queued bytes into the seeds, queues the hashes.
// ----------------------------------------------------------------------------
module cfths_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cfths_pkg::tbl_wr_type         tbl_wr,
   input  cfths_pkg::cmd_type            cmd,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [cfths_pkg::WORD_W-1:0]  rsp_hash_value
);

   localparam int CREDIT_W = cfths_pkg::RSPQ_CNT_W + 1;

   logic [cfths_pkg::WORD_W-1:0]         crypt_mem_ff [cfths_pkg::TABLE_WORDS];
   logic [cfths_pkg::WORD_W-1:0]         rd_data_ff;
   logic                                 s1_valid_ff;
   logic                                 s1_last_ff;
   logic [cfths_pkg::CHAR_W-1:0]         s1_chr_ff;
   logic [cfths_pkg::WORD_W-1:0]         mix_a_ff, mix_a_in;
   logic [cfths_pkg::WORD_W-1:0]         mix_b_ff, mix_b_in;
   logic [cfths_pkg::WORD_W-1:0]         mix_a_next;
   logic [cfths_pkg::WORD_W-1:0]         oq_ff [cfths_pkg::RSPQ_DEPTH];
   logic [cfths_pkg::RSPQ_PTR_W-1:0]     oq_wr_ptr_ff;
   logic [cfths_pkg::RSPQ_PTR_W-1:0]     oq_rd_ptr_ff;
   logic [cfths_pkg::RSPQ_CNT_W-1:0]     oq_count_ff, oq_count_in;
   logic [CREDIT_W-1:0]                  committed;
   logic                                 oq_push;
   logic                                 oq_pop;

   // Issue only when the hash queue has room for everything in flight.
   assign committed = CREDIT_W'(oq_count_ff) + CREDIT_W'(s1_valid_ff);
   assign cmd_pop   = cmd_valid && (committed < CREDIT_W'(cfths_pkg::RSPQ_DEPTH));

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         crypt_mem_ff[tbl_wr.addr] <= tbl_wr.data;
      end
      rd_data_ff <= crypt_mem_ff[cmd.addr];
   end

   assign mix_a_next = rd_data_ff ^ (mix_a_ff + mix_b_ff);

   always_comb begin
      mix_a_in = mix_a_ff;
      mix_b_in = mix_b_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            mix_a_in = cfths_pkg::MIX_A_INIT;
            mix_b_in = cfths_pkg::MIX_B_INIT;
         end else begin
            mix_a_in = mix_a_next;
            mix_b_in = cfths_pkg::WORD_W'(s1_chr_ff) + mix_a_next + mix_b_ff
                       + (mix_b_ff << 5) + cfths_pkg::MIX_B_ADD;
         end
      end
   end

   assign oq_push        = s1_valid_ff && s1_last_ff;
   assign rsp_empty      = (oq_count_ff == '0);
   assign oq_pop         = rsp_pop && !rsp_empty;
   assign rsp_hash_value = oq_ff[oq_rd_ptr_ff];

   always_comb begin
      case ({oq_push, oq_pop})
         2'b10:   oq_count_in = oq_count_ff + 1'b1;
         2'b01:   oq_count_in = oq_count_ff - 1'b1;
         default: oq_count_in = oq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         mix_a_ff     <= cfths_pkg::MIX_A_INIT;
         mix_b_ff     <= cfths_pkg::MIX_B_INIT;
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         s1_valid_ff  <= cmd_pop;
         mix_a_ff     <= mix_a_in;
         mix_b_ff     <= mix_b_in;
         oq_count_ff  <= oq_count_in;
         if (oq_push) begin
            oq_wr_ptr_ff <= oq_wr_ptr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ptr_ff <= oq_rd_ptr_ff + 1'b1;
         end
      end
      s1_last_ff <= cmd.last;
      s1_chr_ff  <= cmd.chr;
      if (oq_push) begin
         oq_ff[oq_wr_ptr_ff] <= mix_a_ff;
      end
   end

endmodule

@@ hdl/case_folded_table_string_hash_unit.sv @@
// ----------------------------------------------------------------------------
// case_folded_table_string_hash_unit
// Table-driven 32-bit string hash, one string byte per beat, case-folded.
// ----------------------------------------------------------------------------
// A string enters one byte per beat on the request queue, with a hash type
// that picks one of five 256-word groups of the crypt table. Letters A to Z
// are folded to lower case before use. A zero byte ends the string: it
// pushes the 32-bit hash onto the response queue and restarts both seeds,
// so an empty string hashes to 0x7FED7FED. Hash types past the last group
// use the last group. After reset the unit builds its 1280-word crypt table
// from a modular LCG and holds req_full high until it is done; each draw
// needs the previous one and passes through the shared reduction datapath
// (multiply, estimate, subtract, fix), two draws per word. Once filled, and
// while the hash consumer keeps up, the unit takes one byte per cycle: a
// front end classifies each byte into a four-entry command queue, and a
// back end reads the table (one registered read port) and updates the
// seeds in the next cycle. A hash reaches the response ports through the
// command queue, the table read register and the response queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module case_folded_table_string_hash_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [cfths_pkg::CHAR_W-1:0]      req_char_in,
   input  logic [cfths_pkg::HTYPE_W-1:0]     req_hash_type,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [cfths_pkg::WORD_W-1:0]      rsp_hash_value
);

   // Table write port, driven only by the generator during the fill.
   cfths_pkg::tbl_wr_type tbl_wr;
   logic                  fill_done;

   // Classified bytes flowing from the front end to the back end.
   cfths_pkg::cmd_type    cmd;
   logic                  cmd_valid;
   logic                  cmd_pop;

   // The generator walks byte index outer, group inner, writing one word
   // after every two draws until the whole table is written.
   cfths_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .tbl_wr    (tbl_wr),
      .fill_done (fill_done)
   );

   // The front end refuses beats until the table is ready and whenever its
   // command queue is full; otherwise it takes a byte every cycle.
   cfths_front u_front (
      .clock         (clock),
      .reset         (reset),
      .fill_done     (fill_done),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_in   (req_char_in),
      .req_hash_type (req_hash_type),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop)
   );

   // The back end pulls a command only when the response queue can still
   // hold every hash already in flight, so a stalled consumer backs up into
   // the command queue and then into req_full without losing anything.
   cfths_back u_back (
      .clock          (clock),
      .reset          (reset),
      .tbl_wr         (tbl_wr),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value)
   );

   // While the table is being built, no byte may get in.
   `CFTHS_ASSERT_IMP(a_full_during_fill, clock, reset, !fill_done, req_full)
   // The back end consumes only real commands, and only from a filled table.
   `CFTHS_ASSERT_IMP(a_pop_needs_entry, clock, reset, cmd_pop, cmd_valid && fill_done)
   // The generator never writes the table once lookups may be under way.
   `CFTHS_ASSERT_IMP(a_no_write_after_fill, clock, reset, tbl_wr.en, !fill_done)
   // A reset restarts the fill and drops any pending hash.
   `CFTHS_ASSERT_NEXT(a_reset_refills, clock, reset, req_full && rsp_empty)

endmodule
